/* hdl/gbr_pkg.sv */
// ============================================================================
// gbr_pkg
// Types, register codes and the elaboration-time Gaussian weight builder
// shared by the RGBA blur block.
// ============================================================================
package gbr_pkg;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Largest window the builder supports (radius 7 gives 15 x 15)
    localparam int MAX_WIN    = 15;
    localparam int MAX_TAPS   = MAX_WIN * MAX_WIN;
    localparam int ROM_W      = 32;
    localparam int SERIES_TERMS = 40;
    localparam int ONE_SHIFT  = 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] r;
    } t_pixel;

    typedef struct packed {
        logic valid;
        logic last;
    } t_item_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic             last;
    } t_result;

    typedef logic [MAX_TAPS-1:0][ROM_W-1:0] t_weight_rom;

    // Shift-subtract quotient, evaluated only while elaborating
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-p/q) in Q30 from a truncated Taylor series
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] p,
                                                input logic [63:0] q);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = 64'd1 << ONE_SHIFT;
        pos  = term;
        neg  = '0;
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            term = udiv64(term * p, q * 64'(k));
            if ((k & 1) != 0) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    // Normalized 2-D Gaussian weights, row-major over the window
    function automatic t_weight_rom gauss_rom(input int radius, input int coef_bits);
        t_weight_rom rom;
        logic [63:0] g [MAX_WIN];
        logic [63:0] s;
        logic [63:0] q;
        logic [63:0] pr;
        int          d;
        int          win;
        rom = '0;
        win = 2 * radius + 1;
        q   = 64'(radius * radius);
        if (q < 64'd4) begin
            q = 64'd4;
        end
        s = '0;
        for (int i = 0; i < MAX_WIN; i++) begin
            g[i] = '0;
        end
        for (int i = 0; i < win; i++) begin
            d    = i - radius;
            g[i] = exp_neg_q30(64'(2 * d * d), q);
            s    = s + g[i];
        end
        if (s == '0) begin
            s = 64'd1;
        end
        for (int i = 0; i < win; i++) begin
            for (int j = 0; j < win; j++) begin
                pr = udiv64(g[i] * g[j], s);
                rom[i * win + j] = ROM_W'(udiv64((pr << coef_bits) + (s >> 1), s));
            end
        end
        return rom;
    endfunction

endpackage

/* hdl/gbr_channels_if.sv */
// ============================================================================
// gbr channel interfaces
// Valid/ready channels for input pixels, blurred results and register writes.
// ============================================================================
interface gbr_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input alpha_in, output ready);
endinterface

interface gbr_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, output frame_last, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input alpha_out, input frame_last, output ready);
endinterface

interface gbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/gbr_window.sv */
// ============================================================================
// gbr_window
// Raster counters, column-wide row store with read-modify-write, and the
// square window shift registers.
// ============================================================================
module gbr_window #(
    parameter int RADIUS    = 2,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  gbr_pkg::t_pixel               i_pixel,
    input  logic [gbr_pkg::FW_W-1:0]      i_frame_width,
    input  logic [gbr_pkg::FH_W-1:0]      i_frame_height,
    output logic                          o_emit,
    output gbr_pkg::t_pixel               o_window [(2*RADIUS+1)*(2*RADIUS+1)],
    output gbr_pkg::t_item_ctl            o_ctl
);
    import gbr_pkg::*;

    localparam int WIN  = 2 * RADIUS + 1;
    localparam int TAPS = WIN * WIN;
    localparam int SR   = 2 * RADIUS;
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int WEW  = (CW > FW_W) ? CW : FW_W;
    localparam int SLW  = $clog2(SR);
    localparam int SSW  = $clog2(2 * SR);

    typedef t_pixel [SR-1:0] t_col_word;

    // Raster position of the next item
    logic [AW-1:0]   r_col;
    logic [FH_W-1:0] r_row;
    logic [SLW-1:0]  r_slot;

    logic [WEW-1:0]  w_raw;
    logic [WEW-1:0]  w_eff;
    logic [FH_W-1:0] h_eff;
    logic [WEW-1:0]  col_inc;
    logic [FH_W:0]   row_inc;
    logic            row_end;
    logic            frame_end;

    // Read stage
    logic            r_v1;
    logic [AW-1:0]   r_col1;
    logic [SLW-1:0]  r_slot1;
    t_pixel          r_pix1;
    logic            r_emit1;
    logic            r_last1;

    t_col_word       r_mem [MAX_WIDTH];
    t_col_word       r_rd;
    logic            r_fwd;
    t_col_word       r_fwd_word;
    t_col_word       base;
    t_col_word       wr_word;
    t_pixel          new_col [SR];

    t_pixel          r_win [TAPS];
    logic            r_ov;
    logic            r_olast;

    always_comb begin
        w_raw = WEW'(i_frame_width);
        if (w_raw > WEW'(MAX_WIDTH)) begin
            w_eff = WEW'(MAX_WIDTH);
        end else if (w_raw == '0) begin
            w_eff = WEW'(1);
        end else begin
            w_eff = w_raw;
        end
        h_eff     = (i_frame_height == '0) ? FH_W'(1) : i_frame_height;
        col_inc   = WEW'(r_col) + WEW'(1);
        row_inc   = {1'b0, r_row} + (FH_W+1)'(1);
        row_end   = col_inc >= w_eff;
        frame_end = row_end && (row_inc >= {1'b0, h_eff});
        o_emit    = (r_col >= AW'(SR)) && (r_row >= FH_W'(SR));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
            r_v1   <= 1'b0;
            r_fwd  <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_v1  <= i_accept;
            r_fwd <= i_accept && r_v1 && (r_col == r_col1);
            r_ov  <= r_v1 && r_emit1;
            if (i_accept) begin
                if (row_end) begin
                    r_col <= '0;
                    if (frame_end) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= row_inc[FH_W-1:0];
                        r_slot <= (r_slot == SLW'(SR - 1)) ? '0 : r_slot + SLW'(1);
                    end
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_col1  <= r_col;
            r_slot1 <= r_slot;
            r_pix1  <= i_pixel;
            r_emit1 <= o_emit;
            r_last1 <= frame_end;
        end
        r_fwd_word <= wr_word;
        r_olast    <= r_last1;
    end

    // Row store: one word per column holds that column of every stored row
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_mem[r_col1] <= wr_word;
        end
        if (i_accept) begin
            r_rd <= r_mem[r_col];
        end
    end

    // Take the write of the item just ahead when it hits the same column
    always_comb begin
        logic [SSW-1:0] phys;
        base    = r_fwd ? r_fwd_word : r_rd;
        wr_word = base;
        wr_word[r_slot1] = r_pix1;
        for (int k = 0; k < SR; k++) begin
            phys = SSW'(r_slot1) + SSW'(k);
            if (phys >= SSW'(SR)) begin
                phys = phys - SSW'(SR);
            end
            new_col[k] = base[SLW'(phys)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN - 1; c++) begin
                    r_win[r * WIN + c] <= r_win[r * WIN + c + 1];
                end
            end
            for (int k = 0; k < SR; k++) begin
                r_win[k * WIN + WIN - 1] <= new_col[k];
            end
            r_win[SR * WIN + WIN - 1] <= r_pix1;
        end
    end

    assign o_window  = r_win;
    assign o_ctl.valid = r_ov;
    assign o_ctl.last  = r_olast;

endmodule

/* hdl/gbr_mac.sv */
// ============================================================================
// gbr_mac
// Per-tap weight multiplies and a registered adder tree for R, G and B,
// with saturation of the scaled sums.
// ============================================================================
module gbr_mac #(
    parameter int RADIUS    = 2,
    parameter int COEF_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gbr_pkg::t_pixel     i_window [(2*RADIUS+1)*(2*RADIUS+1)],
    input  gbr_pkg::t_item_ctl  i_ctl,
    output logic                o_valid,
    output gbr_pkg::t_result    o_result
);
    import gbr_pkg::*;

    localparam int WIN    = 2 * RADIUS + 1;
    localparam int TAPS   = WIN * WIN;
    localparam int CENTRE = RADIUS * WIN + RADIUS;
    localparam int L      = $clog2(TAPS);
    localparam int NP     = 1 << L;
    localparam int WB     = COEF_BITS + 1;
    localparam int PW     = WB + PIX_W;
    localparam int SW     = PW + L;
    localparam int VW     = SW - COEF_BITS;
    localparam int NCH    = 3;

    localparam t_weight_rom W_ROM = gauss_rom(RADIUS, COEF_BITS);

    logic [PIX_W-1:0] tap_val [NCH][TAPS];
    logic [SW-1:0]    r_heap  [NCH][1:2*NP-1];
    logic             r_tv    [0:L];
    logic [PIX_W-1:0] r_ta    [0:L];
    logic             r_tl    [0:L];
    logic [VW-1:0]    scaled  [NCH];
    logic [PIX_W-1:0] sat     [NCH];

    always_comb begin
        for (int t = 0; t < TAPS; t++) begin
            tap_val[0][t] = i_window[t].r;
            tap_val[1][t] = i_window[t].g;
            tap_val[2][t] = i_window[t].b;
        end
    end

    // Leaves hold registered products; each inner node registers the sum of its two children
    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < NCH; ch++) begin
            for (int t = 0; t < NP; t++) begin
                if (t < TAPS) begin
                    r_heap[ch][NP + t] <= SW'(PW'(W_ROM[t][WB-1:0]) * PW'(tap_val[ch][t]));
                end else begin
                    r_heap[ch][NP + t] <= '0;
                end
            end
            for (int n = 1; n < NP; n++) begin
                r_heap[ch][n] <= r_heap[ch][2 * n] + r_heap[ch][2 * n + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l <= L; l++) begin
                r_tv[l] <= 1'b0;
            end
        end else begin
            r_tv[0] <= i_ctl.valid;
            for (int l = 1; l <= L; l++) begin
                r_tv[l] <= r_tv[l - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ta[0] <= i_window[CENTRE].a;
        r_tl[0] <= i_ctl.last;
        for (int l = 1; l <= L; l++) begin
            r_ta[l] <= r_ta[l - 1];
            r_tl[l] <= r_tl[l - 1];
        end
    end

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            scaled[ch] = r_heap[ch][1][SW-1:COEF_BITS];
            sat[ch]    = (scaled[ch] > VW'(255)) ? {PIX_W{1'b1}} : scaled[ch][PIX_W-1:0];
        end
    end

    assign o_valid         = r_tv[L];
    assign o_result.red    = sat[0];
    assign o_result.green  = sat[1];
    assign o_result.blue   = sat[2];
    assign o_result.alpha  = r_ta[L];
    assign o_result.last   = r_tl[L];

endmodule

/* hdl/gbr_out_fifo.sv */
// ============================================================================
// gbr_out_fifo
// Result queue with slot reservation: a slot is taken when an item that will
// produce a result is accepted, so the pipeline never has to stall.
// ============================================================================
module gbr_out_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_reserve,
    input  logic                  i_push,
    input  gbr_pkg::t_result      i_result,
    output logic                  o_has_room,
    gbr_pix_out_if.source         o_pix
);
    import gbr_pkg::*;

    localparam int PTRW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PTRW-1:0] r_wr_ptr;
    logic [PTRW-1:0] r_rd_ptr;
    logic [CNTW-1:0] r_count;
    logic [CNTW-1:0] r_used;
    logic [CNTW-1:0] n_count;
    logic [CNTW-1:0] n_used;
    logic            pop;
    t_result         head;

    assign pop  = o_pix.valid && o_pix.ready;
    assign head = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count + CNTW'(i_push) - CNTW'(pop);
        n_used  = r_used + CNTW'(i_reserve) - CNTW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_used   <= '0;
        end else begin
            r_count <= n_count;
            r_used  <= n_used;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTRW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTRW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    assign o_has_room       = r_used != CNTW'(DEPTH);
    assign o_pix.valid      = r_count != '0;
    assign o_pix.red_out    = head.red;
    assign o_pix.green_out  = head.green;
    assign o_pix.blue_out   = head.blue;
    assign o_pix.alpha_out  = head.alpha;
    assign o_pix.frame_last = head.last;

endmodule

/* hdl/gaussian_blur_rgba_unit.sv */
// ============================================================================
// gaussian_blur_rgba_unit
// Streaming Gaussian blur of RGBA pixels over a square window.
// ============================================================================
// Usage:
//   i_pix takes pixels in raster order. o_pix gives one blurred pixel for each
//   input whose window is complete (column and row both at least 2*RADIUS);
//   border pixels give nothing. frame_last marks the result of the last input
//   of a frame. i_cfg writes frame_width (index 0) and frame_height (index 1);
//   it is always ready and should be written only while the block is idle.
// Pipeline: a result passes a row-store read, a window shift, a multiply stage,
//   one register per adder-tree level and a queue write before it is valid.
// Throughput: one pixel per cycle. The row store keeps a whole column of the
//   stored rows in one word, so each pixel costs one read and one write.
// Stall: results wait in a small output queue; input keeps flowing until
//   every queue slot is promised to an item in flight, then i_pix.ready drops.
// Reset: counters, queue pointers and the frame-size registers return to the
//   power-up values (640 x 480); the row store is not cleared.
// ============================================================================
module gaussian_blur_rgba_unit #(
    parameter int RADIUS    = 2,
    parameter int MAX_WIDTH = 1024,
    parameter int COEF_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gbr_pix_in_if.sink      i_pix,
    gbr_pix_out_if.source   o_pix,
    gbr_cfg_if.sink         i_cfg
);
    import gbr_pkg::*;

    localparam int WIN   = 2 * RADIUS + 1;
    localparam int TAPS  = WIN * WIN;
    localparam int L     = $clog2(TAPS);
    localparam int DEPTH = 1 << $clog2(L + 6);

    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic            accept;
    logic            emit;
    logic            has_room;
    t_pixel          pixel;
    t_pixel          window [TAPS];
    t_item_ctl       win_ctl;
    logic            mac_valid;
    t_result         mac_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(640);
            r_frame_height <= FH_W'(480);
        end else if (i_cfg.valid) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = has_room;
    assign accept      = i_pix.valid && has_room;

    assign pixel.r = i_pix.red_in;
    assign pixel.g = i_pix.green_in;
    assign pixel.b = i_pix.blue_in;
    assign pixel.a = i_pix.alpha_in;

    gbr_window #(
        .RADIUS    (RADIUS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_pixel        (pixel),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_emit         (emit),
        .o_window       (window),
        .o_ctl          (win_ctl)
    );

    gbr_mac #(
        .RADIUS    (RADIUS),
        .COEF_BITS (COEF_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_window (window),
        .i_ctl    (win_ctl),
        .o_valid  (mac_valid),
        .o_result (mac_result)
    );

    gbr_out_fifo #(
        .DEPTH (DEPTH)
    ) u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_reserve  (accept && emit),
        .i_push     (mac_valid),
        .i_result   (mac_result),
        .o_has_room (has_room),
        .o_pix      (o_pix)
    );

endmodule

/* hdl/gbr_checker.sv */
// ============================================================================
// gbr_checker
// Port-level checks on the blur block's result channel.
// ============================================================================
module gbr_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gbr_pix_in_if.sink    i_pix,
    gbr_pix_out_if.source o_pix
);
    logic [31:0] r_bal;
    logic        in_acc;
    logic        out_acc;

    assign in_acc  = i_pix.valid && i_pix.ready;
    assign out_acc = o_pix.valid && o_pix.ready;

    // Inputs accepted minus results taken; hold at the top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal <= '0;
        end else if (in_acc && !out_acc && r_bal != '1) begin
            r_bal <= r_bal + 32'd1;
        end else if (!in_acc && out_acc && r_bal != '0) begin
            r_bal <= r_bal - 32'd1;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix.valid)
        else $error("result valid right after reset");

    a_no_result_without_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> r_bal != '0)
        else $error("result offered with no input item outstanding");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && !o_pix.ready |=> o_pix.valid)
        else $error("result valid dropped while stalled");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && !o_pix.ready |=> $stable(o_pix.red_out) && $stable(o_pix.green_out)
            && $stable(o_pix.blue_out) && $stable(o_pix.alpha_out)
            && $stable(o_pix.frame_last))
        else $error("result payload changed while stalled");

endmodule

bind gaussian_blur_rgba_unit gbr_checker u_gbr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_pix   (i_pix),
    .o_pix   (o_pix)
);
